### rtl/ccmr_pkg.sv
`default_nettype none

package ccmr_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] EV_QUEUED  = 2'd0;
    localparam logic [1:0] EV_DROPPED = 2'd1;
    localparam logic [1:0] EV_HANDLED = 2'd2;

    localparam logic REQ_ROUTE   = 1'b0;
    localparam logic REQ_SERVICE = 1'b1;

    localparam logic [1:0] TGT_A    = 2'd0;
    localparam logic [1:0] TGT_B    = 2'd1;
    localparam logic [1:0] TGT_BOTH = 2'd2;

    localparam logic [15:0] CAP_A_RESET = 16'd1;
    localparam logic [15:0] CAP_B_RESET = 16'd2;

    localparam logic REG_CAP_A = 1'b0;
    localparam logic REG_CAP_B = 1'b1;

    localparam logic Q_A = 1'b0;
    localparam logic Q_B = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  target;
        logic [15:0] cap_id;
        logic [31:0] trace_tag;
        logic [31:0] payload_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic        drop_full;
        logic        queue_index;
        logic [31:0] msg_id;
        logic [31:0] out_trace_id;
        logic [15:0] out_cap_id;
        logic [31:0] out_payload;
        logic        last;
    } evt_t;

    typedef struct packed {
        logic [31:0] msg_id;
        logic [31:0] trace_tag;
        logic [15:0] cap_id;
        logic [31:0] payload_handle;
    } entry_t;

endpackage

`default_nettype wire

### rtl/ccmr_if.sv
`default_nettype none

interface ccmr_req_if;
    import ccmr_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ccmr_evt_if;
    import ccmr_pkg::*;

    logic valid;
    logic ready;
    evt_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/capability_checked_message_router.sv
// capability checked message router
// req_ch carries route and service transactions, evt_ch carries one event
// transaction per delivery or pop, with last set on the final one of a request.
// a route transaction mints a message id per target queue, checks the
// capability against the queue's allowed value and queues or drops it; a
// service transaction pops at most one entry from queue A and then from B.
// each queue holds QUEUE_DEPTH-1 entries in its own memory.
// requests are held in the input register, events in the event register.
// a request stays in the input register until its last event is registered,
// or until the event register is free if it produces none; the next request
// can be taken as it leaves. the allowed capabilities are to be written over
// the apb port only while idle, by the user; the block does not enforce it.
// reset clears pointers, the id counter and the handshake state and loads the
// default capabilities; queue memories are not cleared.
// when evt_ch stalls, the event register holds and the request waiting in the
// input register holds too, so req_ch.ready drops until the event is taken.
`default_nettype none

module capability_checked_message_router #(
    parameter int QUEUE_DEPTH = ccmr_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ccmr_req_if.sink                               req_ch,
    ccmr_evt_if.source                             evt_ch,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ccmr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ccmr_pkg::APB_DATA_W-1:0]   pwdata,
    output      logic [ccmr_pkg::APB_DATA_W-1:0]   prdata,
    output      logic                              pready
);
    import ccmr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [PTR_W-1:0] ptr_t;

    function automatic ptr_t adv(input ptr_t p);
        adv = (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    logic [15:0] cap_a_reg;
    logic [15:0] cap_b_reg;
    logic        cfg_wr;

    req_t        job_reg;
    logic        job_valid_reg;
    logic        job_valid_next;
    logic        step_reg;
    logic        step_next;

    evt_t        out_reg;
    evt_t        out_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [31:0] msg_counter_reg;
    logic [31:0] msg_counter_next;

    ptr_t        rd_ptr_reg [2];
    ptr_t        rd_ptr_next [2];
    ptr_t        wr_ptr_reg [2];
    ptr_t        wr_ptr_next [2];
    entry_t      rdata_reg [2];
    logic        wr_en [2];
    logic        pop [2];
    entry_t      wdata;

    logic        accept;
    logic        out_free;
    logic        is_route;
    logic        a_app;
    logic        b_app;
    logic        do_a;
    logic        do_b;
    logic        emit;
    logic        sel_q;
    logic        job_done;
    logic [15:0] allowed;
    logic        cap_ok;
    logic        full;
    logic [31:0] id_new;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_CAP_A: prdata = {{(APB_DATA_W-16){1'b0}}, cap_a_reg};
            REG_CAP_B: prdata = {{(APB_DATA_W-16){1'b0}}, cap_b_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_a_reg <= CAP_A_RESET;
            cap_b_reg <= CAP_B_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CAP_A: cap_a_reg <= pwdata[15:0];
                REG_CAP_B: cap_b_reg <= pwdata[15:0];
                default:   cap_a_reg <= cap_a_reg;
            endcase
        end
    end

    // per cycle decision: at most one queue is served
    always_comb
    begin
        out_free = !out_valid_reg || evt_ch.ready;
        is_route = (job_reg.req_type == REQ_ROUTE);
        if (is_route)
        begin
            a_app = (job_reg.target == TGT_A) || (job_reg.target == TGT_BOTH);
            b_app = (job_reg.target == TGT_B) || (job_reg.target == TGT_BOTH);
        end
        else
        begin
            a_app = (rd_ptr_reg[0] != wr_ptr_reg[0]);
            b_app = (rd_ptr_reg[1] != wr_ptr_reg[1]);
        end
        do_a     = job_valid_reg && out_free && !step_reg && a_app;
        do_b     = job_valid_reg && out_free && !do_a && b_app;
        emit     = do_a || do_b;
        sel_q    = do_b ? Q_B : Q_A;
        job_done = job_valid_reg && out_free && !(do_a && b_app);

        allowed = (sel_q == Q_B) ? cap_b_reg : cap_a_reg;
        cap_ok  = (job_reg.cap_id == allowed);
        full    = (adv(wr_ptr_reg[sel_q]) == rd_ptr_reg[sel_q]);
        id_new  = msg_counter_reg + 32'd1;

        wdata.msg_id         = id_new;
        wdata.trace_tag      = job_reg.trace_tag;
        wdata.cap_id         = job_reg.cap_id;
        wdata.payload_handle = job_reg.payload_handle;

        out_next.queue_index = sel_q;
        out_next.last        = do_b || !b_app;
        if (is_route)
        begin
            out_next.event_res    = (cap_ok && !full) ? EV_QUEUED : EV_DROPPED;
            out_next.drop_full    = cap_ok && full;
            out_next.msg_id       = id_new;
            out_next.out_trace_id = job_reg.trace_tag;
            out_next.out_cap_id   = job_reg.cap_id;
            out_next.out_payload  = job_reg.payload_handle;
        end
        else
        begin
            out_next.event_res    = EV_HANDLED;
            out_next.drop_full    = 1'b0;
            out_next.msg_id       = rdata_reg[sel_q].msg_id;
            out_next.out_trace_id = rdata_reg[sel_q].trace_tag;
            out_next.out_cap_id   = rdata_reg[sel_q].cap_id;
            out_next.out_payload  = rdata_reg[sel_q].payload_handle;
        end

        msg_counter_next = (emit && is_route) ? id_new : msg_counter_reg;

        for (int q = 0; q < 2; q++)
        begin
            wr_en[q] = emit && is_route && (sel_q == q[0]) && cap_ok && !full;
            pop[q]   = emit && !is_route && (sel_q == q[0]);
            wr_ptr_next[q] = wr_en[q] ? adv(wr_ptr_reg[q]) : wr_ptr_reg[q];
            rd_ptr_next[q] = pop[q] ? adv(rd_ptr_reg[q]) : rd_ptr_reg[q];
        end

        accept         = req_ch.valid && req_ch.ready;
        job_valid_next = accept ? 1'b1 : (job_done ? 1'b0 : job_valid_reg);
        step_next      = job_done ? 1'b0 : (do_a ? 1'b1 : step_reg);
        out_valid_next = emit ? 1'b1 : (evt_ch.ready ? 1'b0 : out_valid_reg);
    end

    assign req_ch.ready   = !job_valid_reg || job_done;
    assign evt_ch.valid   = out_valid_reg;
    assign evt_ch.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg   <= 1'b0;
            step_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            msg_counter_reg <= '0;
            for (int q = 0; q < 2; q++)
            begin
                rd_ptr_reg[q] <= '0;
                wr_ptr_reg[q] <= '0;
            end
        end
        else
        begin
            job_valid_reg   <= job_valid_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
            msg_counter_reg <= msg_counter_next;
            for (int q = 0; q < 2; q++)
            begin
                rd_ptr_reg[q] <= rd_ptr_next[q];
                wr_ptr_reg[q] <= wr_ptr_next[q];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= req_ch.payload;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    // queue storage, head entry kept registered with write bypass
    for (genvar g = 0; g < 2; g++)
    begin : g_queue
        entry_t mem [QUEUE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en[g])
            begin
                mem[wr_ptr_reg[g]] <= wdata;
            end
            if (wr_en[g] && (wr_ptr_reg[g] == rd_ptr_next[g]))
            begin
                rdata_reg[g] <= wdata;
            end
            else
            begin
                rdata_reg[g] <= mem[rd_ptr_next[g]];
            end
        end
    end

endmodule

`default_nettype wire

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ccmr_pkg::*;

    localparam int QDEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_LEN = 100;
    localparam int PHASE_ITEMS = 225;
    localparam logic [1:0] TGT_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    ccmr_req_if req_ch ();
    ccmr_evt_if evt_ch ();

    capability_checked_message_router u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_ch),
        .evt_ch  (evt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // routing state mirrored from the block
    entry_t      slot_store [2][QDEPTH];
    int unsigned rd_ptr [2];
    int unsigned wr_ptr [2];
    logic [31:0] id_count;
    logic [15:0] cap_allow [2];

    req_t req_backlog [$];
    evt_t events_due [$];

    int send_idle_pct = 36;
    int recv_idle_pct = 68;
    int mismatches = 0;
    int hold_count = 0;
    logic pressure_arm = 1'b0;
    int cycle_count = 0;

    function automatic evt_t deliver(logic q, req_t r);
        evt_t e;
        int unsigned nxt;
        id_count = id_count + 32'd1;
        nxt = (wr_ptr[q] + 1) % QDEPTH;
        e.queue_index  = q;
        e.msg_id       = id_count;
        e.out_trace_id = r.trace_tag;
        e.out_cap_id   = r.cap_id;
        e.out_payload  = r.payload_handle;
        e.last         = 1'b0;
        e.drop_full    = 1'b0;
        if (r.cap_id != cap_allow[q]) begin
            e.event_res = EV_DROPPED;
        end else if (nxt == rd_ptr[q]) begin
            e.event_res = EV_DROPPED;
            e.drop_full = 1'b1;
        end else begin
            slot_store[q][wr_ptr[q]] = '{id_count, r.trace_tag, r.cap_id, r.payload_handle};
            wr_ptr[q] = nxt;
            e.event_res = EV_QUEUED;
        end
        return e;
    endfunction

    function automatic bit pop_entry(logic q, output evt_t e);
        entry_t s;
        e = '0;
        if (rd_ptr[q] == wr_ptr[q])
            return 1'b0;
        s = slot_store[q][rd_ptr[q]];
        e.event_res    = EV_HANDLED;
        e.queue_index  = q;
        e.msg_id       = s.msg_id;
        e.out_trace_id = s.trace_tag;
        e.out_cap_id   = s.cap_id;
        e.out_payload  = s.payload_handle;
        rd_ptr[q] = (rd_ptr[q] + 1) % QDEPTH;
        return 1'b1;
    endfunction

    function automatic void compute_events(req_t r);
        evt_t ev [$];
        evt_t e;
        if (r.req_type == REQ_ROUTE) begin
            if (r.target == TGT_A || r.target == TGT_BOTH)
                ev.push_back(deliver(Q_A, r));
            if (r.target == TGT_B || r.target == TGT_BOTH)
                ev.push_back(deliver(Q_B, r));
        end else begin
            if (pop_entry(Q_A, e))
                ev.push_back(e);
            if (pop_entry(Q_B, e))
                ev.push_back(e);
        end
        if (ev.size() != 0)
            ev[ev.size() - 1].last = 1'b1;
        foreach (ev[i])
            events_due.push_back(ev[i]);
    endfunction

    function automatic req_t route_item(logic [1:0] tgt, logic [15:0] cap,
                                        logic [31:0] trace, logic [31:0] pay);
        req_t r;
        r.req_type = REQ_ROUTE;
        r.target = tgt;
        r.cap_id = cap;
        r.trace_tag = trace;
        r.payload_handle = pay;
        return r;
    endfunction

    function automatic req_t service_item();
        req_t r;
        r.req_type = REQ_SERVICE;
        r.target = 2'($urandom);
        r.cap_id = 16'($urandom);
        r.trace_tag = $urandom;
        r.payload_handle = $urandom;
        return r;
    endfunction

    function automatic req_t random_item(int svc_pct);
        req_t r;
        int pick;
        logic [15:0] want_cap;
        if ($urandom_range(99) < svc_pct)
            return service_item();
        if ($urandom_range(99) < 4) begin
            r = route_item(TGT_UNUSED, 16'($urandom), $urandom, $urandom);
            return r;
        end
        case ($urandom_range(2))
            0: r.target = TGT_A;
            1: r.target = TGT_B;
            default: r.target = TGT_BOTH;
        endcase
        if (r.target == TGT_B || (r.target == TGT_BOTH && $urandom_range(1) == 1))
            want_cap = cap_allow[Q_B];
        else
            want_cap = cap_allow[Q_A];
        pick = $urandom_range(99);
        if (pick < 70)
            want_cap = want_cap;
        else if (pick < 85)
            want_cap = want_cap ^ (16'd1 << $urandom_range(15));
        else
            want_cap = 16'($urandom);
        return route_item(r.target, want_cap, $urandom, $urandom);
    endfunction

    task automatic check_field(string field_name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field_name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic cap_write(logic reg_index, logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cap_allow[reg_index] = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_ch.valid || events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int n_items);
        int done_items;
        int svc_pct;
        req_t r;
        done_items = 0;
        svc_pct = 35;
        while (done_items < n_items) begin
            if (done_items % 30 == 0) begin
                case ($urandom_range(2))
                    0: svc_pct = 5;
                    1: svc_pct = 35;
                    default: svc_pct = 75;
                endcase
            end
            r = random_item(svc_pct);
            req_backlog.push_back(r);
            if (!(r.req_type == REQ_ROUTE && r.target == TGT_UNUSED))
                done_items++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                compute_events(req_ch.payload);
            if (!req_ch.valid || req_ch.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.valid <= 1'b1;
                    req_ch.payload <= req_backlog.pop_front();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold, counted in cycles
    always @(posedge clk)
    begin
        if (rst_n && pressure_arm && hold_count < HOLD_LEN)
            hold_count <= hold_count + 1;
    end

    // event monitor and receiver
    always @(posedge clk)
    begin
        evt_t want;
        if (!rst_n) begin
            evt_ch.ready <= 1'b0;
        end else begin
            if (evt_ch.valid && evt_ch.ready) begin
                if (events_due.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %0h",
                             $time, evt_ch.payload);
                    mismatches++;
                end else begin
                    want = events_due.pop_front();
                    check_field("event_res", 32'(want.event_res),
                                32'(evt_ch.payload.event_res));
                    check_field("drop_full", 32'(want.drop_full),
                                32'(evt_ch.payload.drop_full));
                    check_field("queue_index", 32'(want.queue_index),
                                32'(evt_ch.payload.queue_index));
                    check_field("msg_id", want.msg_id, evt_ch.payload.msg_id);
                    check_field("out_trace_id", want.out_trace_id,
                                evt_ch.payload.out_trace_id);
                    check_field("out_cap_id", 32'(want.out_cap_id),
                                32'(evt_ch.payload.out_cap_id));
                    check_field("out_payload", want.out_payload, evt_ch.payload.out_payload);
                    check_field("last", 32'(want.last), 32'(evt_ch.payload.last));
                end
            end
            if (pressure_arm && hold_count < HOLD_LEN) begin
                evt_ch.ready <= 1'b0;
            end else begin
                evt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        logic [15:0] cap_a;
        logic [15:0] cap_b;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        evt_ch.ready = 1'b0;
        rd_ptr = '{0, 0};
        wr_ptr = '{0, 0};
        id_count = '0;
        cap_allow[Q_A] = CAP_A_RESET;
        cap_allow[Q_B] = CAP_B_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capabilities: both queues, mixed capabilities, unused target
        req_backlog.push_back(route_item(TGT_A, CAP_A_RESET, 32'h0, 32'hffff_ffff));
        req_backlog.push_back(route_item(TGT_B, CAP_B_RESET, 32'hffff_ffff, 32'h0));
        req_backlog.push_back(route_item(TGT_BOTH, CAP_A_RESET, $urandom, $urandom));
        req_backlog.push_back(route_item(TGT_BOTH, CAP_B_RESET, $urandom, $urandom));
        req_backlog.push_back(route_item(TGT_UNUSED, CAP_A_RESET, $urandom, $urandom));
        repeat (3) req_backlog.push_back(service_item());
        // fill queue A past its capacity, then a rejected capability on the full queue
        repeat (QDEPTH) req_backlog.push_back(route_item(TGT_A, CAP_A_RESET, $urandom, $urandom));
        req_backlog.push_back(route_item(TGT_A, 16'hffff, $urandom, $urandom));
        req_backlog.push_back(service_item());
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cap_a = 16'h0000; cap_b = 16'hffff; end
                1: begin cap_a = 16'hffff; cap_b = 16'h0000; end
                2: begin cap_a = 16'h1234; cap_b = 16'h1234; end
                5: begin cap_a = 16'hffff; cap_b = 16'hffff; end
                default: begin cap_a = 16'($urandom); cap_b = 16'($urandom); end
            endcase
            if (ph < 2) begin
                send_idle_pct = 36;
                recv_idle_pct = 68;
            end else if (ph < 4) begin
                send_idle_pct = 68;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cap_write(REG_CAP_A, cap_a);
            cap_write(REG_CAP_B, cap_b);
            if (ph == 4)
                pressure_arm <= 1'b1;
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
